[hw/rtl/sfp_pkg.sv]
// Package for the scanner frame parser: constants, op codes, front/back word struct.
// No dependencies.
package sfp_pkg;
  localparam logic [15:0] HEAD_CODE     = 16'hAAAA;
  localparam logic [15:0] DISTANCE_CODE = 16'h0001;
  localparam logic [15:0] STATUS_CODE   = 16'h0002;
  localparam int          WINDOW_SLOTS  = 5;
  localparam int          SLOT_W        = $clog2(WINDOW_SLOTS + 1);
  localparam int          IDX_W         = $clog2(WINDOW_SLOTS);
  localparam logic [27:0] DIST_TRAILER  = 28'hEEEEEEE;
  localparam logic [31:0] STAT_TRAILER  = 32'hEEEEEEEE;
  localparam logic [7:0]  TEMP_NEG_LIMIT = 8'd20;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_DIST  = 2'd1;
  localparam logic [1:0] KIND_STAT  = 2'd2;

  typedef enum logic [2:0] {
    OP_POINT, OP_DTRAIL, OP_MOTOR, OP_DUST, OP_TEMP, OP_ZERO, OP_STRAIL
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] data;
  } cmd_t;

  localparam logic [2:0] REG_MOTOR_EN  = 3'd0;
  localparam logic [2:0] REG_NPN       = 3'd1;
  localparam logic [2:0] REG_MOTOR_LIM = 3'd2;
  localparam logic [2:0] REG_ZERO_LIM  = 3'd3;
  localparam logic [2:0] REG_DUST_LIM  = 3'd4;
  localparam logic [2:0] REG_TEMP_LIM  = 3'd5;

  function automatic logic [7:0] nib_char(input logic [3:0] n);
    nib_char = (n <= 4'd9) ? {4'h3, n} : (8'h37 + {4'h0, n});
  endfunction
endpackage

[hw/rtl/sfp_front.sv]
// Front part: frame state machine, turns stream words into back-end commands.
// Depends on sfp_pkg.
module sfp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [31:0]   word_in,
  output logic          cmd_valid,
  output sfp_pkg::cmd_t cmd,
  input  logic          cmd_full
);
  import sfp_pkg::*;

  typedef enum logic [2:0] {
    S_HUNT, S_LEN, S_DDATA, S_DTRAIL, S_SWORDS, S_STRAIL
  } state_t;

  state_t      state;
  logic [1:0]  fkind;
  logic [31:0] words_left;
  logic [2:0]  sidx;
  logic        in_take;

  assign in_take = in_valid && !cmd_full;

  always_comb begin
    cmd_valid = 1'b0;
    cmd.data  = word_in;
    cmd.op    = OP_POINT;
    case (state)
      S_DDATA:  begin cmd_valid = in_take; cmd.op = OP_POINT; end
      S_DTRAIL: begin cmd_valid = in_take; cmd.op = OP_DTRAIL; end
      S_SWORDS: begin
        cmd_valid = in_take && (sidx != 3'd1);
        case (sidx)
          3'd0:    cmd.op = OP_MOTOR;
          3'd2:    cmd.op = OP_DUST;
          3'd3:    cmd.op = OP_TEMP;
          default: cmd.op = OP_ZERO;
        endcase
      end
      S_STRAIL: begin cmd_valid = in_take; cmd.op = OP_STRAIL; end
      default:  cmd_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
      fkind <= KIND_POINT;
      words_left <= '0;
      sidx <= '0;
    end else if (in_take) begin
      case (state)
        S_HUNT: if (word_in[31:16] == HEAD_CODE) begin
          state <= S_LEN;
          if (word_in[15:0] == DISTANCE_CODE)    fkind <= KIND_DIST;
          else if (word_in[15:0] == STATUS_CODE) fkind <= KIND_STAT;
          else                                   fkind <= KIND_POINT;
        end
        S_LEN: begin
          sidx <= '0;
          if (fkind == KIND_DIST) begin
            words_left <= word_in;
            state <= (word_in == 32'd0) ? S_DTRAIL : S_DDATA;
          end else if (fkind == KIND_STAT) begin
            state <= S_SWORDS;
          end else begin
            state <= S_HUNT;
          end
        end
        S_DDATA: begin
          words_left <= words_left - 32'd1;
          if (words_left == 32'd1) state <= S_DTRAIL;
        end
        S_SWORDS: begin
          if (sidx >= 3'd4) state <= S_STRAIL;
          else sidx <= sidx + 3'd1;
        end
        default: state <= S_HUNT;
      endcase
    end
  end
endmodule

[hw/rtl/sfp_queue.sv]
// Two-entry queue between front and back parts.
// Depends on sfp_pkg.
module sfp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  sfp_pkg::cmd_t wdata,
  output logic          full,
  output logic          rd_valid,
  output sfp_pkg::cmd_t rdata,
  input  logic          rd
);
  import sfp_pkg::*;

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rdata    = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

[hw/rtl/sfp_back.sv]
// Back part: window slots, alarm evaluation and result register.
// Depends on sfp_pkg.
module sfp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  sfp_pkg::cmd_t cmd,
  output logic          cmd_take,
  input  logic          motor_run,
  input  logic          npn_board,
  input  logic [31:0]   motor_count_limit,
  input  logic [31:0]   zero_width_limit,
  input  logic [31:0]   dust_limit,
  input  logic [7:0]    temp_high_limit,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    kind,
  output logic [31:0]   distance_text,
  output logic [15:0]   gray_text,
  output logic          frame_ok,
  output logic [2:0]    zone_alarm,
  output logic          motor_alarm,
  output logic          laser_alarm,
  output logic          dust_alarm,
  output logic          temp_alarm,
  output logic          report_alarm,
  output logic          update_position
);
  import sfp_pkg::*;

  logic [31:0] motor_win [WINDOW_SLOTS];
  logic [31:0] dust_win  [WINDOW_SLOTS];
  logic [31:0] zero_win  [WINDOW_SLOTS];
  logic [15:0] temp_last;
  logic [SLOT_W-1:0] slot;
  logic [IDX_W-1:0]  s;
  logic [3:0]  alarms;
  logic        pos_flag;
  logic [2:0]  region_held;
  logic        m_all, l_all, d_all, t_hit, ok;
  logic [3:0]  alarms_next;
  logic        emits;

  assign s     = (slot >= SLOT_W'(WINDOW_SLOTS)) ? '0 : slot[IDX_W-1:0];
  assign emits = (cmd.op == OP_POINT) || (cmd.op == OP_DTRAIL) || (cmd.op == OP_STRAIL);
  assign cmd_take = cmd_valid && (!emits || !out_valid || !out_stall);

  // Windows only change on status words, so flags below are stable when the trailer lands.
  always_comb begin
    m_all = motor_run;
    l_all = 1'b1;
    d_all = 1'b1;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      if (!(motor_win[i] >= motor_count_limit)) m_all = 1'b0;
      if (!(zero_win[i] < zero_width_limit))    l_all = 1'b0;
      if (!(dust_win[i] > dust_limit))          d_all = 1'b0;
    end
    t_hit = temp_last[13] ? (temp_last[7:0] > TEMP_NEG_LIMIT)
                          : (temp_last[7:0] > temp_high_limit);
    alarms_next = {t_hit, d_all, l_all, m_all};
  end

  assign ok = (cmd.op == OP_STRAIL) ? (cmd.data == STAT_TRAILER)
                                    : (cmd.data[27:0] == DIST_TRAILER);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot <= '0;
      alarms <= '0;
      pos_flag <= 1'b0;
      region_held <= '0;
      temp_last <= '0;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        motor_win[i] <= '0;
        dust_win[i] <= '0;
        zero_win[i] <= '0;
      end
    end else begin
      if (!out_valid || !out_stall) out_valid <= cmd_take && emits;
      if (cmd_take) begin
        case (cmd.op)
          OP_MOTOR: if (!alarms[0]) motor_win[s] <= cmd.data;
          OP_DUST:  if (!alarms[2]) dust_win[s] <= cmd.data;
          OP_TEMP: begin
            if (!alarms[3] && s == IDX_W'(WINDOW_SLOTS - 1)) temp_last <= cmd.data[15:0];
            pos_flag <= cmd.data[31];
          end
          OP_ZERO: begin
            if (!alarms[1]) zero_win[s] <= cmd.data;
            slot <= SLOT_W'(s) + SLOT_W'(1);
          end
          OP_POINT: begin
            kind <= KIND_POINT;
            distance_text <= {nib_char(cmd.data[15:12]), nib_char(cmd.data[11:8]),
                              nib_char(cmd.data[7:4]), nib_char(cmd.data[3:0])};
            gray_text <= {nib_char(cmd.data[23:20]), nib_char(cmd.data[19:16])};
            frame_ok <= 1'b0;
            zone_alarm <= '0;
            {temp_alarm, dust_alarm, laser_alarm, motor_alarm} <= '0;
            report_alarm <= 1'b0;
            update_position <= 1'b0;
          end
          OP_DTRAIL: begin
            kind <= KIND_DIST;
            distance_text <= '0;
            gray_text <= '0;
            frame_ok <= ok;
            if (ok) begin
              region_held <= npn_board ? ~cmd.data[30:28] : cmd.data[30:28];
              zone_alarm <= npn_board ? ~cmd.data[30:28] : cmd.data[30:28];
            end else begin
              zone_alarm <= region_held;
            end
            {temp_alarm, dust_alarm, laser_alarm, motor_alarm} <= alarms;
            report_alarm <= |alarms;
            update_position <= pos_flag;
          end
          default: begin
            kind <= KIND_STAT;
            distance_text <= '0;
            gray_text <= '0;
            frame_ok <= ok;
            zone_alarm <= region_held;
            update_position <= pos_flag;
            if (ok && slot == SLOT_W'(WINDOW_SLOTS)) begin
              alarms <= alarms_next;
              {temp_alarm, dust_alarm, laser_alarm, motor_alarm} <= alarms_next;
              report_alarm <= |alarms_next;
            end else begin
              {temp_alarm, dust_alarm, laser_alarm, motor_alarm} <= alarms;
              report_alarm <= |alarms;
            end
          end
        endcase
      end
    end
  end
endmodule

[hw/rtl/scanner_frame_parser_unit.sv]
// Top level of the scanner frame parser: APB registers, front, queue, back.
// Depends on sfp_pkg, sfp_front, sfp_queue, sfp_back.
//
//  channel | direction | handshake             | payload
//  in      | into      | in_valid / in_stall   | word_in
//  out     | out of    | out_valid / out_stall | kind .. update_position
//  cfg     | into      | APB psel/penable      | paddr, pwdata, prdata
//
// One word per cycle sustained while out_stall stays low. A word lands in the
// two-entry queue when it is accepted; the back part loads the result register
// from the queue head unless the output stall holds it, then raises out_valid.
// Reset clears frame state, windows, alarms and loads register defaults.
// An output stall holds the result register; the queue absorbs two words,
// then in_stall rises for every word, header and length words included.
module scanner_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] word_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] distance_text,
  output logic [15:0] gray_text,
  output logic        frame_ok,
  output logic [2:0]  zone_alarm,
  output logic        motor_alarm,
  output logic        laser_alarm,
  output logic        dust_alarm,
  output logic        temp_alarm,
  output logic        report_alarm,
  output logic        update_position,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sfp_pkg::*;

  logic        motor_run, npn_board;
  logic [31:0] motor_count_limit, zero_width_limit, dust_limit;
  logic [7:0]  temp_high_limit;
  logic [2:0]  reg_idx;
  logic        f_valid, q_full, q_valid, q_take;
  cmd_t        f_cmd, q_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_run <= 1'b1;
      npn_board <= 1'b0;
      motor_count_limit <= '1;
      zero_width_limit <= '0;
      dust_limit <= '1;
      temp_high_limit <= 8'd80;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MOTOR_EN:  motor_run <= pwdata[0];
        REG_NPN:       npn_board <= pwdata[0];
        REG_MOTOR_LIM: motor_count_limit <= pwdata;
        REG_ZERO_LIM:  zero_width_limit <= pwdata;
        REG_DUST_LIM:  dust_limit <= pwdata;
        REG_TEMP_LIM:  temp_high_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MOTOR_EN:  prdata = {31'd0, motor_run};
      REG_NPN:       prdata = {31'd0, npn_board};
      REG_MOTOR_LIM: prdata = motor_count_limit;
      REG_ZERO_LIM:  prdata = zero_width_limit;
      REG_DUST_LIM:  prdata = dust_limit;
      REG_TEMP_LIM:  prdata = {24'd0, temp_high_limit};
      default:       prdata = '0;
    endcase
  end

  sfp_front u_front (
    .clk, .rst, .in_valid, .word_in,
    .cmd_valid(f_valid), .cmd(f_cmd), .cmd_full(q_full)
  );

  sfp_queue u_queue (
    .clk, .rst, .wr(f_valid), .wdata(f_cmd), .full(q_full),
    .rd_valid(q_valid), .rdata(q_cmd), .rd(q_take)
  );

  sfp_back u_back (
    .clk, .rst, .cmd_valid(q_valid), .cmd(q_cmd), .cmd_take(q_take),
    .motor_run, .npn_board, .motor_count_limit, .zero_width_limit,
    .dust_limit, .temp_high_limit,
    .out_valid, .out_stall, .kind, .distance_text, .gray_text, .frame_ok,
    .zone_alarm, .motor_alarm, .laser_alarm, .dust_alarm, .temp_alarm,
    .report_alarm, .update_position
  );
endmodule
